// ===== sv/wsdf_pkg.sv =====
`default_nettype none

package wsdf_pkg;

  localparam int unsigned LEN_BITS_DEFAULT = 64;

  localparam logic [7:0] FLAGS_OK        = 8'h81;
  localparam logic [6:0] LEN7_MASK       = 7'h7F;
  localparam logic [6:0] LEN7_MAX_DIRECT = 7'd125;
  localparam logic [6:0] LEN7_EXT16      = 7'd126;
  localparam logic [6:0] LEN7_EXT64      = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PAYLOAD  = 2'd0;
  localparam kind_t KIND_EMPTY    = 2'd1;
  localparam kind_t KIND_BADFLAGS = 2'd2;

endpackage

`default_nettype wire

// ===== sv/websocket_frame_deframer_top.sv =====
// WebSocket client-to-server deframer.
// Input channel: one raw stream byte per request (data_valid/data_ready,
// data_byte). Output channel: one result per request that produces one
// (result_valid/result_ready, kind, out_byte, last_of_frame).
// kind: payload byte (unmasked, last_of_frame on the final one), empty frame
// (last_of_frame set), or bad flags byte (first byte of a frame not 0x81;
// the next byte is taken as a new frame start). Flags, length, extension and
// mask bytes that do not finish a frame give no result.
// A result is registered: result_valid rises in the cycle after its byte is
// accepted. Throughput: one byte per cycle while data_ready is high, set by the
// single register stage holding the parser state and the result register.
// The length counter is LEN_BITS wide; one decrement and compare per payload byte.
// Stall: while a result is held and result_ready is low, data_ready is low;
// data_ready is high whenever the result register is empty or being drained.
// Reset (rst, synchronous, active high): parser returns to awaiting a flags
// byte, length and mask state clear, the result register empties.
`default_nettype none

module websocket_frame_deframer_top #(
  parameter int unsigned LEN_BITS = wsdf_pkg::LEN_BITS_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  data_valid,
  output logic                 data_ready,
  input  wire  [7:0]           data_byte,
  output logic                 result_valid,
  input  wire                  result_ready,
  output wsdf_pkg::kind_t      kind,
  output logic [7:0]           out_byte,
  output logic                 last_of_frame
);

  localparam logic [2:0] PH_FLAGS   = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]          phase, phase_next;
  logic [3:0]          ext_left, ext_left_next;
  logic [LEN_BITS-1:0] len_cnt, len_cnt_next;
  logic [31:0]         mask_key, mask_key_next;
  logic [1:0]          mask_seen, mask_seen_next;
  logic [1:0]          mask_pos, mask_pos_next;

  logic                emit;
  wsdf_pkg::kind_t     kind_next;
  logic [7:0]          out_byte_next;
  logic                last_next;
  logic [6:0]          len7;
  logic [7:0]          key_byte;
  logic                accept;

  assign data_ready = !result_valid || result_ready;
  assign accept     = data_valid && data_ready;
  assign len7       = data_byte[6:0] & wsdf_pkg::LEN7_MASK;

  always_comb begin
    unique case (mask_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next     = phase;
    ext_left_next  = ext_left;
    len_cnt_next   = len_cnt;
    mask_key_next  = mask_key;
    mask_seen_next = mask_seen;
    mask_pos_next  = mask_pos;
    emit           = 1'b0;
    kind_next      = wsdf_pkg::KIND_PAYLOAD;
    out_byte_next  = 8'd0;
    last_next      = 1'b0;
    unique case (phase)
      PH_FLAGS: begin
        if (data_byte != wsdf_pkg::FLAGS_OK) begin
          emit      = 1'b1;
          kind_next = wsdf_pkg::KIND_BADFLAGS;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        len_cnt_next   = '0;
        mask_seen_next = 2'd0;
        mask_key_next  = 32'd0;
        if (len7 <= wsdf_pkg::LEN7_MAX_DIRECT) begin
          len_cnt_next  = LEN_BITS'(len7);
          ext_left_next = 4'd0;
          phase_next    = PH_MASK;
        end else if (len7 == wsdf_pkg::LEN7_EXT16) begin
          ext_left_next = wsdf_pkg::EXT16_BYTES;
          phase_next    = PH_EXT;
        end else begin
          ext_left_next = wsdf_pkg::EXT64_BYTES;
          phase_next    = PH_EXT;
        end
      end
      PH_EXT: begin
        len_cnt_next  = {len_cnt[LEN_BITS-9:0], data_byte};
        ext_left_next = ext_left - 4'd1;
        if (ext_left == 4'd1) begin
          phase_next = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], data_byte};
        if (mask_seen == 2'd3) begin
          mask_seen_next = 2'd0;
          mask_pos_next  = 2'd0;
          if (len_cnt == '0) begin
            phase_next = PH_FLAGS;
            emit       = 1'b1;
            kind_next  = wsdf_pkg::KIND_EMPTY;
            last_next  = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          mask_seen_next = mask_seen + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        len_cnt_next  = len_cnt - LEN_BITS'(1);
        mask_pos_next = mask_pos + 2'd1;
        emit          = 1'b1;
        kind_next     = wsdf_pkg::KIND_PAYLOAD;
        out_byte_next = data_byte ^ key_byte;
        last_next     = (len_cnt == LEN_BITS'(1));
        if (len_cnt == LEN_BITS'(1)) begin
          phase_next = PH_FLAGS;
        end
      end
      default: begin
        phase_next = PH_FLAGS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FLAGS;
      ext_left     <= 4'd0;
      len_cnt      <= '0;
      mask_key     <= 32'd0;
      mask_seen    <= 2'd0;
      mask_pos     <= 2'd0;
      result_valid <= 1'b0;
    end else begin
      if (accept && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        phase     <= phase_next;
        ext_left  <= ext_left_next;
        len_cnt   <= len_cnt_next;
        mask_key  <= mask_key_next;
        mask_seen <= mask_seen_next;
        mask_pos  <= mask_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind          <= kind_next;
      out_byte      <= out_byte_next;
      last_of_frame <= last_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wsdf_checker.sv =====
`default_nettype none

module wsdf_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  data_ready,
  input wire                  result_valid,
  input wire                  result_ready,
  input wsdf_pkg::kind_t      kind,
  input wire [7:0]            out_byte,
  input wire                  last_of_frame
);

  // held result must not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(kind) && $stable(out_byte) && $stable(last_of_frame))
    else $error("result changed while stalled");

  // input side is never blocked when the result register is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> data_ready)
    else $error("data_ready low with empty result register");

  // only payload results carry data
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != wsdf_pkg::KIND_PAYLOAD |-> out_byte == 8'd0)
    else $error("nonzero out_byte on non-payload result");

  // empty frame ends a frame, bad flags never does
  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == wsdf_pkg::KIND_EMPTY || kind == wsdf_pkg::KIND_BADFLAGS)
      |-> last_of_frame == (kind == wsdf_pkg::KIND_EMPTY))
    else $error("last_of_frame wrong for kind");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid after reset");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (.*);

`default_nettype wire
